// ===== hdl/stok_pkg.sv =====
// Shared types, token codes, keyword table and helpers for the source tokenizer.
package stok_pkg;

  // Default configuration
  localparam int KeywordBytesDef   = 16;
  localparam int FractionDigitsDef = 9;

  // Token kinds
  localparam logic [5:0] TkLparen  = 6'd0;
  localparam logic [5:0] TkRparen  = 6'd1;
  localparam logic [5:0] TkLbrack  = 6'd2;
  localparam logic [5:0] TkRbrack  = 6'd3;
  localparam logic [5:0] TkLbrace  = 6'd4;
  localparam logic [5:0] TkRbrace  = 6'd5;
  localparam logic [5:0] TkColon   = 6'd6;
  localparam logic [5:0] TkComma   = 6'd7;
  localparam logic [5:0] TkDot     = 6'd8;
  localparam logic [5:0] TkPlus    = 6'd9;
  localparam logic [5:0] TkMinus   = 6'd10;
  localparam logic [5:0] TkStar    = 6'd11;
  localparam logic [5:0] TkSlash   = 6'd12;
  localparam logic [5:0] TkEq      = 6'd13;
  localparam logic [5:0] TkEqEq    = 6'd14;
  localparam logic [5:0] TkNeq     = 6'd15;
  localparam logic [5:0] TkLt      = 6'd16;
  localparam logic [5:0] TkGt      = 6'd17;
  localparam logic [5:0] TkLeq     = 6'd18;
  localparam logic [5:0] TkGeq     = 6'd19;
  localparam logic [5:0] TkNumber  = 6'd44;
  localparam logic [5:0] TkString  = 6'd45;
  localparam logic [5:0] TkName    = 6'd46;
  localparam logic [5:0] TkNewline = 6'd47;
  localparam logic [5:0] TkError   = 6'd48;
  localparam logic [5:0] TkEnd     = 6'd49;
  localparam logic [5:0] TkText    = 6'd50;
  localparam logic [5:0] TkMax     = TkText;

  // Character codes
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  // Scanner modes
  typedef enum logic [12:0] {
    ModeIdle   = 13'b0000000000001,
    ModeHead   = 13'b0000000000010,
    ModeName   = 13'b0000000000100,
    ModeNum    = 13'b0000000001000,
    ModeStr    = 13'b0000000010000,
    ModeEsc    = 13'b0000000100000,
    ModeLcom   = 13'b0000001000000,
    ModeBcom   = 13'b0000010000000,
    ModePeq    = 13'b0000100000000,
    ModePlt    = 13'b0001000000000,
    ModePgt    = 13'b0010000000000,
    ModePbang  = 13'b0100000000000,
    ModePslash = 13'b1000000000000
  } mode_e;

  // Scanner state of fixed width
  typedef struct packed {
    mode_e       mode;
    logic [15:0] line;
    logic [15:0] col;
    logic [1:0]  group_left;
    logic [30:0] int_acc;
    logic [29:0] frac_acc;
    logic [3:0]  frac_cnt;
    logic        point;
    logic [7:0]  prev;
  } scan_t;

  // One result item
  typedef struct packed {
    logic        last;
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [30:0] int_part;
    logic [29:0] frac_val;
    logic [3:0]  frac_cnt;
    logic        is_frac;
    logic [7:0]  text;
  } result_t;

  // Keyword table: bytes in reading order from the top bit down
  localparam int KwCount = 26;
  localparam logic [127:0] KwWord [KwCount] = '{
    {80'hd0bfd183d181d182d18c, 48'h0},
    {32'hd184d0bd, 96'h0},
    {64'hd0b5d181d0bbd0b8, 64'h0},
    {80'hd0b8d0bdd0b0d187d0b5, 48'h0},
    {112'hd0b8d0bbd0b8d0b5d181d0bbd0b8, 16'h0},
    {64'hd0bfd0bed0bad0b0, 64'h0},
    {48'hd0b4d0bbd18f, 80'h0},
    {32'hd0b8d0b7, 96'h0},
    {80'hd0b2d0b5d180d0bdd0b8, 48'h0},
    {96'hd0b2d18bd0b2d0b5d0b4d0b8, 32'h0},
    {80'hd0bdd0b8d187d182d0be, 48'h0},
    {96'hd0b8d181d182d0b8d0bdd0b0, 32'h0},
    {64'hd0bbd0bed0b6d18c, 64'h0},
    {80'hd0b2d18bd185d0bed0b4, 48'h0},
    {112'hd181d0bfd180d0b0d0b2d0bad0b0, 16'h0},
    {16'hd0b8, 112'h0},
    {48'hd0b8d0bbd0b8, 80'h0},
    {128'hd0bfd0bed0bfd180d0bed0b1d183d0b9},
    {64'hd0bbd0bed0b2d0b8, 64'h0},
    {96'hd0b1d180d0bed181d0b0d0b9, 32'h0},
    {64'hd181d182d0bed0bf, 64'h0},
    {96'hd0b4d0b0d0bbd18cd188d0b5, 32'h0},
    {80'hd0b2d18bd0b1d0bed180, 48'h0},
    {96'hd181d0bbd183d187d0b0d0b9, 32'h0},
    {96'hd0bbd18fd0bcd0b1d0b4d0b0, 32'h0},
    {96'hd0b8d0bcd0bfd0bed180d182, 32'h0}
  };
  localparam logic [4:0] KwLen [KwCount] = '{
    5'd10, 5'd4, 5'd8, 5'd10, 5'd14, 5'd8, 5'd6, 5'd4, 5'd10, 5'd12,
    5'd10, 5'd12, 5'd8, 5'd10, 5'd14, 5'd2, 5'd6, 5'd16, 5'd8, 5'd12,
    5'd8, 5'd12, 5'd10, 5'd12, 5'd12, 5'd12
  };
  localparam logic [5:0] KwCode [KwCount] = '{
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd30, 6'd31, 6'd32, TkEnd, 6'd43, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37,
    6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43
  };

  // Parallel keyword match; first table entry wins
  function automatic logic [5:0] kw_lookup(logic [15:0][7:0] name, logic [4:0] len);
    logic [5:0] code;
    logic       hit;
    code = TkName;
    for (int i = KwCount - 1; i >= 0; i--) begin
      hit = (KwLen[i] == len);
      for (int j = 0; j < 16; j++) begin
        if (5'(j) < len && name[j] != KwWord[i][127 - 8*j -: 8]) hit = 1'b0;
      end
      if (hit) code = KwCode[i];
    end
    return code;
  endfunction

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_decimal(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return b >= 8'h80 || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)
           || b == 8'h5F;
  endfunction

  // Continuation bytes still to come after a group's lead byte
  function automatic logic [1:0] group_rest(logic [7:0] b);
    return (b < 8'h80) ? 2'd0 : (b < 8'hE0) ? 2'd1 : 2'd2;
  endfunction

  function automatic result_t mk_res(logic [5:0] kind, logic [15:0] line,
                                     logic [15:0] col, logic [7:0] text);
    result_t r;
    r = '0;
    r.kind = kind;
    r.line = line;
    r.col  = col;
    r.text = text;
    return r;
  endfunction

endpackage

// ===== hdl/stok_step.sv =====
// Next-state and result logic for one source byte of the tokenizer.
module stok_step #(
  parameter int KeywordBytes   = stok_pkg::KeywordBytesDef,
  parameter int FractionDigits = stok_pkg::FractionDigitsDef,
  localparam int LenW = $clog2(KeywordBytes + 2),
  localparam int IdxW = $clog2(KeywordBytes)
) (
  input  stok_pkg::scan_t                    st_q_i,
  input  logic [LenW-1:0]                    len_q_i,
  input  logic [KeywordBytes-1:0][7:0]       name_q_i,
  input  logic [7:0]                         byte_i,
  input  logic                               eos_i,
  output stok_pkg::scan_t                    st_d_o,
  output logic [LenW-1:0]                    len_d_o,
  output logic                               name_we_o,
  output logic [IdxW-1:0]                    name_idx_o,
  output stok_pkg::result_t [1:0]            res_o,
  output logic [1:0]                         res_cnt_o
);
  import stok_pkg::*;

  localparam logic [LenW-1:0] KbLen = LenW'(KeywordBytes);

  always_comb begin
    scan_t          s;
    logic [LenW-1:0] ln;
    result_t        ra, rb, ri;
    logic           ha, hb, hi, rescan, fin;
    logic [15:0]    c_line, c_col, line_before;
    logic [3:0]     dig;
    logic [34:0]    iv;
    logic [33:0]    fv;
    logic [5:0]     code;

    s = st_q_i;
    ln = len_q_i;
    ra = '0; rb = '0; ri = '0;
    ha = 1'b0; hb = 1'b0; hi = 1'b0; rescan = 1'b0;
    name_we_o = 1'b0;
    name_idx_o = '0;
    fin = eos_i || (byte_i == 8'h00);
    c_line = (byte_i == ChLf) ? sat_inc16(st_q_i.line) : st_q_i.line;
    c_col  = (byte_i == ChLf) ? 16'd0 : sat_inc16(st_q_i.col);
    dig = 4'(byte_i - 8'h30);
    iv = (35'(st_q_i.int_acc) << 3) + (35'(st_q_i.int_acc) << 1) + 35'(dig);
    fv = (34'(st_q_i.frac_acc) << 3) + (34'(st_q_i.frac_acc) << 1) + 34'(dig);
    code = TkName;
    if (len_q_i <= KbLen && len_q_i <= LenW'(16)) begin
      code = kw_lookup(name_q_i[15:0], 5'(len_q_i));
    end

    // Continue or close the token in progress
    unique case (st_q_i.mode)
      ModeHead, ModeName: begin
        if (!fin && (st_q_i.group_left != 2'd0 || is_decimal(byte_i) || is_alpha(byte_i))) begin
          s.prev = byte_i;
          if (st_q_i.group_left != 2'd0 && st_q_i.mode == ModeHead) begin
            s.col = sat_inc16(st_q_i.col);
          end else begin
            s.line = c_line;
            s.col  = c_col;
          end
          if (ln < KbLen) begin
            name_we_o  = 1'b1;
            name_idx_o = ln[IdxW-1:0];
          end
          if (ln <= KbLen) ln = ln + LenW'(1);
          ra = mk_res(TkText, s.line, s.col, byte_i);
          ha = 1'b1;
          if (st_q_i.group_left != 2'd0) begin
            s.group_left = st_q_i.group_left - 2'd1;
            if (st_q_i.group_left == 2'd1) s.mode = ModeName;
          end else if (!is_decimal(byte_i)) begin
            s.group_left = group_rest(byte_i);
          end
        end else begin
          ra = mk_res(code, st_q_i.line, st_q_i.col, 8'h00);
          ha = 1'b1;
          rescan = 1'b1;
        end
      end
      ModeNum: begin
        if (!fin && is_decimal(byte_i)) begin
          s.prev = byte_i; s.line = c_line; s.col = c_col;
          if (!st_q_i.point) begin
            s.int_acc = (iv > 35'h7FFFFFFF) ? 31'h7FFFFFFF : iv[30:0];
          end else if (st_q_i.frac_cnt < 4'(FractionDigits)) begin
            s.frac_acc = fv[29:0];
            s.frac_cnt = st_q_i.frac_cnt + 4'd1;
          end
        end else if (!fin && byte_i == 8'h2E && !st_q_i.point) begin
          s.prev = byte_i; s.line = c_line; s.col = c_col;
          s.point = 1'b1;
        end else begin
          ra = mk_res(TkNumber, st_q_i.line, st_q_i.col, 8'h00);
          ra.int_part = st_q_i.int_acc;
          ra.frac_val = st_q_i.frac_acc;
          ra.frac_cnt = st_q_i.frac_cnt;
          ra.is_frac  = st_q_i.point;
          ha = 1'b1;
          rescan = 1'b1;
        end
      end
      ModeStr: begin
        if (fin || byte_i == ChLf) begin
          ra = mk_res(TkString, st_q_i.line, st_q_i.col, 8'h00);
          ha = 1'b1;
          rescan = 1'b1;
        end else begin
          s.prev = byte_i; s.line = c_line; s.col = c_col;
          if (byte_i == ChQuote) begin
            ra = mk_res(TkString, c_line, c_col, 8'h00);
            ha = 1'b1;
            s.mode = ModeIdle;
          end else if (byte_i == ChBslash) begin
            s.mode = ModeEsc;
          end else begin
            ra = mk_res(TkText, c_line, c_col, byte_i);
            ha = 1'b1;
          end
        end
      end
      ModeEsc: begin
        if (fin) begin
          ra = mk_res(TkString, st_q_i.line, st_q_i.col, 8'h00);
          ha = 1'b1;
          rescan = 1'b1;
        end else begin
          s.prev = byte_i; s.line = c_line; s.col = c_col;
          ra = mk_res(TkText, c_line, c_col,
                      (byte_i == 8'h6E) ? ChLf : (byte_i == 8'h74) ? ChTab :
                      (byte_i == 8'h72) ? ChCr : byte_i);
          ha = 1'b1;
          s.mode = ModeStr;
        end
      end
      ModeLcom: begin
        if (fin || byte_i == ChLf) begin
          rescan = 1'b1;
        end else begin
          s.prev = byte_i; s.line = c_line; s.col = c_col;
        end
      end
      ModeBcom: begin
        if (fin) begin
          rescan = 1'b1;
        end else begin
          s.prev = byte_i; s.line = c_line; s.col = c_col;
          if (st_q_i.prev == 8'h2A && byte_i == 8'h2F) s.mode = ModeIdle;
        end
      end
      ModePeq, ModePlt, ModePgt, ModePbang: begin
        if (!fin && byte_i == 8'h3D) begin
          s.prev = byte_i; s.line = c_line; s.col = c_col;
          ra = mk_res((st_q_i.mode == ModePeq) ? TkEqEq : (st_q_i.mode == ModePlt) ? TkLeq :
                      (st_q_i.mode == ModePgt) ? TkGeq : TkNeq, c_line, c_col, 8'h00);
          ha = 1'b1;
          s.mode = ModeIdle;
        end else begin
          if (st_q_i.mode == ModePbang) begin
            ra = mk_res(TkError, st_q_i.line, 16'd0, 8'h00);
          end else begin
            ra = mk_res((st_q_i.mode == ModePeq) ? TkEq : (st_q_i.mode == ModePlt) ? TkLt : TkGt,
                        st_q_i.line, st_q_i.col, 8'h00);
          end
          ha = 1'b1;
          rescan = 1'b1;
        end
      end
      ModePslash: begin
        if (!fin && (byte_i == 8'h2F || byte_i == 8'h2A)) begin
          s.prev = byte_i; s.line = c_line; s.col = c_col;
          s.mode = (byte_i == 8'h2F) ? ModeLcom : ModeBcom;
        end else begin
          ra = mk_res(TkSlash, st_q_i.line, st_q_i.col, 8'h00);
          ha = 1'b1;
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // Scan the byte afresh from idle; counters are still the incoming ones
    if (rescan) begin
      s.mode = ModeIdle;
      line_before = st_q_i.line;
      if (fin) begin
        ri = mk_res(TkEnd, st_q_i.line, st_q_i.col, 8'h00);
        hi = 1'b1;
        ln = '0; s.group_left = '0; s.int_acc = '0; s.frac_acc = '0;
        s.frac_cnt = '0; s.point = 1'b0;
      end else begin
        s.prev = byte_i; s.line = c_line; s.col = c_col;
        hi = 1'b1;
        case (byte_i)
          ChSpace, ChTab, ChCr: hi = 1'b0;
          ChLf: ri = mk_res(TkNewline, line_before, 16'd0, 8'h00);
          8'h28: ri = mk_res(TkLparen, c_line, c_col, 8'h00);
          8'h29: ri = mk_res(TkRparen, c_line, c_col, 8'h00);
          8'h5B: ri = mk_res(TkLbrack, c_line, c_col, 8'h00);
          8'h5D: ri = mk_res(TkRbrack, c_line, c_col, 8'h00);
          8'h7B: ri = mk_res(TkLbrace, c_line, c_col, 8'h00);
          8'h7D: ri = mk_res(TkRbrace, c_line, c_col, 8'h00);
          8'h3A: ri = mk_res(TkColon, c_line, c_col, 8'h00);
          8'h2C: ri = mk_res(TkComma, c_line, c_col, 8'h00);
          8'h2E: ri = mk_res(TkDot, c_line, c_col, 8'h00);
          8'h2B: ri = mk_res(TkPlus, c_line, c_col, 8'h00);
          8'h2D: ri = mk_res(TkMinus, c_line, c_col, 8'h00);
          8'h2A: ri = mk_res(TkStar, c_line, c_col, 8'h00);
          8'h3D: begin hi = 1'b0; s.mode = ModePeq; end
          8'h3C: begin hi = 1'b0; s.mode = ModePlt; end
          8'h3E: begin hi = 1'b0; s.mode = ModePgt; end
          8'h21: begin hi = 1'b0; s.mode = ModePbang; end
          8'h2F: begin hi = 1'b0; s.mode = ModePslash; end
          ChQuote: begin hi = 1'b0; s.mode = ModeStr; end
          default: begin
            if (is_decimal(byte_i)) begin
              hi = 1'b0;
              ln = '0; s.group_left = '0; s.frac_acc = '0; s.frac_cnt = '0;
              s.point = 1'b0;
              s.int_acc = 31'(dig);
              s.mode = ModeNum;
            end else if (is_alpha(byte_i)) begin
              s.int_acc = '0; s.frac_acc = '0; s.frac_cnt = '0; s.point = 1'b0;
              name_we_o  = 1'b1;
              name_idx_o = '0;
              ln = LenW'(1);
              ri = mk_res(TkText, c_line, c_col, byte_i);
              s.group_left = group_rest(byte_i);
              s.mode = (group_rest(byte_i) != 2'd0) ? ModeHead : ModeName;
            end else begin
              ri = mk_res(TkError, c_line, 16'd0, 8'h00);
            end
          end
        endcase
      end
    end

    // Pack results into slots and mark the final one
    if (hi) begin
      if (ha) begin
        rb = ri; hb = 1'b1;
      end else begin
        ra = ri; ha = 1'b1;
      end
    end
    if (hb) rb.last = 1'b1;
    else if (ha) ra.last = 1'b1;

    st_d_o    = s;
    len_d_o   = ln;
    res_o[0]  = ra;
    res_o[1]  = rb;
    res_cnt_o = {hb, ha & ~hb};
  end

endmodule

// ===== hdl/source_tokenizer_core.sv =====
// Top level of the source tokenizer: scanner state, name buffer and result queue.
//
// The tokenizer takes one source byte per clock while s_axis_tready is high and
// produces zero, one or two results for it (a closing token followed by what the
// byte itself starts). A byte is scanned combinationally by the step logic between
// the scanner state registers and a four-entry result queue; results leave one per
// clock while m_axis_tready is high, so the sustained rate is one byte per cycle
// while bytes yield at most one result each, and is set by the single result port
// otherwise. s_axis_tready is high while the queue has room for two results, so
// input keeps flowing while earlier results wait at the output. Results are
// written into the queue as their byte is taken and leave behind earlier ones.
module source_tokenizer_core #(
  parameter int KeywordBytes   = stok_pkg::KeywordBytesDef,
  parameter int FractionDigits = stok_pkg::FractionDigitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] source_byte
  input  logic         s_axis_tuser,  // [0] end_of_source
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // [15:0] token_line, [31:16] token_column,
                                      // [62:32] int_part, [92:63] frac_digits_value,
                                      // [96:93] frac_digit_count, [97] is_fractional,
                                      // [105:98] text_byte, [111:106] zero
  output logic [5:0]   m_axis_tuser,  // [5:0] token_kind
  output logic         m_axis_tlast   // last_of_step
);
  import stok_pkg::*;

  localparam int LenW = $clog2(KeywordBytes + 2);
  localparam int IdxW = $clog2(KeywordBytes);

  scan_t                      st_q, st_d;
  logic [LenW-1:0]            len_q, len_d;
  logic [KeywordBytes-1:0][7:0] name_q;
  logic                       name_we;
  logic [IdxW-1:0]            name_idx;
  result_t [1:0]              res;
  logic [1:0]                 res_cnt;

  result_t                    fifo_q [4];
  logic [1:0]                 wr_q, rd_q;
  logic [2:0]                 cnt_q;
  logic                       in_req, out_req;

  assign s_axis_tready = (cnt_q <= 3'd2);
  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign out_req = m_axis_tvalid && m_axis_tready;

  stok_step #(
    .KeywordBytes  (KeywordBytes),
    .FractionDigits(FractionDigits)
  ) u_step (
    .st_q_i    (st_q),
    .len_q_i   (len_q),
    .name_q_i  (name_q),
    .byte_i    (s_axis_tdata),
    .eos_i     (s_axis_tuser),
    .st_d_o    (st_d),
    .len_d_o   (len_d),
    .name_we_o (name_we),
    .name_idx_o(name_idx),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '{mode: ModeIdle, line: 16'd1, default: '0};
      len_q      <= '0;
    end else if (in_req) begin
      st_q  <= st_d;
      len_q <= len_d;
    end
  end

  // Name byte buffer
  always_ff @(posedge clk_i) begin
    if (in_req && name_we) name_q[name_idx] <= s_axis_tdata;
  end

  // Result queue payload
  always_ff @(posedge clk_i) begin
    if (in_req && res_cnt != 2'd0) begin
      fifo_q[wr_q] <= res[0];
      if (res_cnt == 2'd2) fifo_q[wr_q + 2'd1] <= res[1];
    end
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_req) wr_q <= wr_q + res_cnt;
      if (out_req) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + (in_req ? 3'(res_cnt) : 3'd0) - (out_req ? 3'd1 : 3'd0);
    end
  end

  // Output channel
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tuser  = fifo_q[rd_q].kind;
  assign m_axis_tlast  = fifo_q[rd_q].last;
  assign m_axis_tdata  = {6'd0, fifo_q[rd_q].text, fifo_q[rd_q].is_frac,
                          fifo_q[rd_q].frac_cnt, fifo_q[rd_q].frac_val,
                          fifo_q[rd_q].int_part, fifo_q[rd_q].col, fifo_q[rd_q].line};

endmodule

// ===== hdl/stok_checker.sv =====
// Port-level checks for the source tokenizer, bound to the top level.
module stok_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic [5:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import stok_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Token kind in range
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= TkMax)
    else $error("token kind out of range");

  // Number fields only on number tokens
  a_num_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != TkNumber |-> m_axis_tdata[97:32] == '0)
    else $error("number fields set on non-number token");

  // Text byte only on text results
  a_text_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != TkText |-> m_axis_tdata[105:98] == '0)
    else $error("text byte set on non-text result");

  // Newline and error carry column zero
  a_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == TkNewline || m_axis_tuser == TkError)
    |-> m_axis_tdata[31:16] == 16'd0)
    else $error("column not zero on newline or error");

endmodule

bind source_tokenizer_core stok_checker u_stok_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for the source tokenizer core.
`timescale 1ns / 1ps

module tb;
  import stok_pkg::*;

  localparam logic [5:0] NoKind = 6'h3F;  // table row with no typed expectation
  localparam int RandomItems = 380;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [5:0]   m_axis_tuser;
  logic         m_axis_tlast;

  source_tokenizer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Scanner copy
  mode_e       lx_mode;
  logic [15:0] lx_line;
  logic [15:0] lx_col;
  logic [7:0]  lx_name [16];
  logic [4:0]  lx_nlen;
  logic [1:0]  lx_grp;
  logic [30:0] lx_int;
  logic [29:0] lx_frac;
  logic [3:0]  lx_fcnt;
  logic        lx_point;
  logic [7:0]  lx_prev;

  result_t tokens_due [$];
  result_t step_tokens [$];
  int      errors = 0;
  int      tokens_seen = 0;
  int      bytes_taken = 0;

  function automatic logic [15:0] bump16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit dec_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit name_char(logic [7:0] b);
    return b >= 8'h80 || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)
           || b == 8'h5F;
  endfunction

  function automatic logic [1:0] utf8_rest(logic [7:0] b);
    return (b < 8'h80) ? 2'd0 : (b < 8'hE0) ? 2'd1 : 2'd2;
  endfunction

  function automatic void put_token(logic [5:0] kind, logic [15:0] line,
                                    logic [15:0] col, logic [7:0] text);
    result_t r;
    r = '0;
    r.kind = kind;
    r.line = line;
    r.col  = col;
    r.text = text;
    step_tokens.push_back(r);
  endfunction

  function automatic void take_byte(logic [7:0] b);
    lx_prev = b;
    lx_col  = bump16(lx_col);
    if (b == ChLf) begin
      lx_line = bump16(lx_line);
      lx_col  = '0;
    end
  endfunction

  function automatic void keep_name(logic [7:0] b);
    if (lx_nlen < 16) lx_name[lx_nlen] = b;
    if (lx_nlen <= 16) lx_nlen++;
  endfunction

  function automatic void clear_token();
    lx_mode  = ModeIdle;
    lx_nlen  = '0;
    lx_grp   = '0;
    lx_int   = '0;
    lx_frac  = '0;
    lx_fcnt  = '0;
    lx_point = 1'b0;
  endfunction

  // Name closes: keyword match on names of up to 16 bytes, first entry wins
  function automatic void finish_name();
    logic [5:0] kind;
    bit         hit;
    kind = TkName;
    if (lx_nlen <= 16) begin
      for (int k = 0; k < KwCount; k++) begin
        hit = (KwLen[k] == lx_nlen);
        for (int j = 0; j < 16; j++)
          if (j < lx_nlen && lx_name[j] != KwWord[k][127-8*j -: 8]) hit = 0;
        if (hit) begin
          kind = KwCode[k];
          break;
        end
      end
    end
    put_token(kind, lx_line, lx_col, 8'h00);
  endfunction

  // Byte seen with no token open
  function automatic void start_token(bit eos, logic [7:0] b);
    logic [15:0] line_was;
    line_was = lx_line;
    if (eos) begin
      put_token(TkEnd, lx_line, lx_col, 8'h00);
      clear_token();
      return;
    end
    take_byte(b);
    case (b)
      ChSpace, ChTab, ChCr: ;
      ChLf:  put_token(TkNewline, line_was, 16'd0, 8'h00);
      8'h28: put_token(TkLparen, lx_line, lx_col, 8'h00);
      8'h29: put_token(TkRparen, lx_line, lx_col, 8'h00);
      8'h5B: put_token(TkLbrack, lx_line, lx_col, 8'h00);
      8'h5D: put_token(TkRbrack, lx_line, lx_col, 8'h00);
      8'h7B: put_token(TkLbrace, lx_line, lx_col, 8'h00);
      8'h7D: put_token(TkRbrace, lx_line, lx_col, 8'h00);
      8'h3A: put_token(TkColon, lx_line, lx_col, 8'h00);
      8'h2C: put_token(TkComma, lx_line, lx_col, 8'h00);
      8'h2E: put_token(TkDot, lx_line, lx_col, 8'h00);
      8'h2B: put_token(TkPlus, lx_line, lx_col, 8'h00);
      8'h2D: put_token(TkMinus, lx_line, lx_col, 8'h00);
      8'h2A: put_token(TkStar, lx_line, lx_col, 8'h00);
      8'h3D: lx_mode = ModePeq;
      8'h3C: lx_mode = ModePlt;
      8'h3E: lx_mode = ModePgt;
      8'h21: lx_mode = ModePbang;
      8'h2F: lx_mode = ModePslash;
      ChQuote: lx_mode = ModeStr;
      default: begin
        if (dec_digit(b)) begin
          clear_token();
          lx_int  = 31'(b - 8'h30);
          lx_mode = ModeNum;
        end else if (name_char(b)) begin
          clear_token();
          keep_name(b);
          put_token(TkText, lx_line, lx_col, b);
          lx_grp  = utf8_rest(b);
          lx_mode = (lx_grp != 0) ? ModeHead : ModeName;
        end else begin
          put_token(TkError, lx_line, 16'd0, 8'h00);
        end
      end
    endcase
  endfunction

  // One accepted request: append the tokens it causes to tokens_due
  function automatic void lex_byte(logic [7:0] b, logic eos_in);
    bit          e;
    bit          rescan;
    bit          star;
    logic [7:0]  d;
    logic [63:0] v;
    e = eos_in || b == 8'h00;
    rescan = 0;
    step_tokens.delete();
    case (lx_mode)
      ModeHead, ModeName: begin
        if (!e && lx_grp > 0) begin
          if (lx_mode == ModeHead) begin
            lx_prev = b;
            lx_col  = bump16(lx_col);
          end else take_byte(b);
          keep_name(b);
          put_token(TkText, lx_line, lx_col, b);
          lx_grp--;
          if (lx_grp == 0) lx_mode = ModeName;
        end else if (!e && dec_digit(b)) begin
          take_byte(b);
          keep_name(b);
          put_token(TkText, lx_line, lx_col, b);
        end else if (!e && name_char(b)) begin
          take_byte(b);
          keep_name(b);
          put_token(TkText, lx_line, lx_col, b);
          lx_grp = utf8_rest(b);
        end else begin
          finish_name();
          rescan = 1;
        end
      end
      ModeNum: begin
        if (!e && dec_digit(b)) begin
          take_byte(b);
          if (!lx_point) begin
            v = 64'(lx_int) * 10 + 64'(b - 8'h30);
            lx_int = (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(v);
          end else if (lx_fcnt < FractionDigitsDef) begin
            lx_frac = lx_frac * 10 + 30'(b - 8'h30);
            lx_fcnt++;
          end
        end else if (!e && b == 8'h2E && !lx_point) begin
          take_byte(b);
          lx_point = 1'b1;
        end else begin
          put_token(TkNumber, lx_line, lx_col, 8'h00);
          step_tokens[$].int_part = lx_int;
          step_tokens[$].frac_val = lx_frac;
          step_tokens[$].frac_cnt = lx_fcnt;
          step_tokens[$].is_frac  = lx_point;
          rescan = 1;
        end
      end
      ModeStr: begin
        if (e || b == ChLf) begin
          put_token(TkString, lx_line, lx_col, 8'h00);
          rescan = 1;
        end else if (b == ChQuote) begin
          take_byte(b);
          put_token(TkString, lx_line, lx_col, 8'h00);
          lx_mode = ModeIdle;
        end else if (b == ChBslash) begin
          take_byte(b);
          lx_mode = ModeEsc;
        end else begin
          take_byte(b);
          put_token(TkText, lx_line, lx_col, b);
        end
      end
      ModeEsc: begin
        if (e) begin
          put_token(TkString, lx_line, lx_col, 8'h00);
          rescan = 1;
        end else begin
          d = b;
          if (b == 8'h6E) d = ChLf;
          else if (b == 8'h74) d = ChTab;
          else if (b == 8'h72) d = ChCr;
          take_byte(b);
          put_token(TkText, lx_line, lx_col, d);
          lx_mode = ModeStr;
        end
      end
      ModeLcom: begin
        if (e || b == ChLf) rescan = 1;
        else take_byte(b);
      end
      ModeBcom: begin
        if (e) rescan = 1;
        else begin
          star = (lx_prev == 8'h2A);
          take_byte(b);
          if (star && b == 8'h2F) lx_mode = ModeIdle;
        end
      end
      ModePeq, ModePlt, ModePgt, ModePbang: begin
        if (!e && b == 8'h3D) begin
          take_byte(b);
          case (lx_mode)
            ModePeq: put_token(TkEqEq, lx_line, lx_col, 8'h00);
            ModePlt: put_token(TkLeq, lx_line, lx_col, 8'h00);
            ModePgt: put_token(TkGeq, lx_line, lx_col, 8'h00);
            default: put_token(TkNeq, lx_line, lx_col, 8'h00);
          endcase
          lx_mode = ModeIdle;
        end else begin
          case (lx_mode)
            ModePeq: put_token(TkEq, lx_line, lx_col, 8'h00);
            ModePlt: put_token(TkLt, lx_line, lx_col, 8'h00);
            ModePgt: put_token(TkGt, lx_line, lx_col, 8'h00);
            default: put_token(TkError, lx_line, 16'd0, 8'h00);
          endcase
          rescan = 1;
        end
      end
      ModePslash: begin
        if (!e && b == 8'h2F) begin
          take_byte(b);
          lx_mode = ModeLcom;
        end else if (!e && b == 8'h2A) begin
          take_byte(b);
          lx_mode = ModeBcom;
        end else begin
          put_token(TkSlash, lx_line, lx_col, 8'h00);
          rescan = 1;
        end
      end
      default: rescan = 1;
    endcase
    if (rescan) begin
      lx_mode = ModeIdle;
      start_token(e, b);
    end
    foreach (step_tokens[k]) begin
      step_tokens[k].last = (k == step_tokens.size() - 1);
      tokens_due.push_back(step_tokens[k]);
    end
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Token checker
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        report("unexpected token kind", m_axis_tuser, 64'h0);
      end else begin
        w = tokens_due.pop_front();
        if (m_axis_tuser != w.kind) report("kind", m_axis_tuser, w.kind);
        if (m_axis_tdata[15:0] != w.line) report("line", m_axis_tdata[15:0], w.line);
        if (m_axis_tdata[31:16] != w.col) report("column", m_axis_tdata[31:16], w.col);
        if (m_axis_tdata[62:32] != w.int_part)
          report("int_part", m_axis_tdata[62:32], w.int_part);
        if (m_axis_tdata[92:63] != w.frac_val)
          report("frac value", m_axis_tdata[92:63], w.frac_val);
        if (m_axis_tdata[96:93] != w.frac_cnt)
          report("frac count", m_axis_tdata[96:93], w.frac_cnt);
        if (m_axis_tdata[97] != w.is_frac) report("is_fractional", m_axis_tdata[97], w.is_frac);
        if (m_axis_tdata[105:98] != w.text) report("text", m_axis_tdata[105:98], w.text);
        if (m_axis_tlast != w.last) report("last", m_axis_tlast, w.last);
      end
    end
  end

  // Receiver stall pattern, with a randomly chosen style
  int unsigned stall_style = 0;
  int unsigned stall_cyc = 0;
  always @(negedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 64 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (stall_cyc % 5 >= 2);
      default: m_axis_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  // Source bytes to send
  logic [7:0] src_bytes [$];
  logic       src_eos [$];

  function automatic void add_byte(logic [7:0] b);
    src_bytes.push_back(b);
    src_eos.push_back(1'b0);
  endfunction

  function automatic void add_digits(int n);
    for (int i = 0; i < n; i++) add_byte(8'h30 + 8'($urandom_range(0, 9)));
  endfunction

  // One random fragment of source text, mostly well formed
  function automatic void add_fragment();
    int k;
    int n;
    case ($urandom_range(0, 13))
      0, 1: begin
        k = $urandom_range(0, KwCount - 1);
        for (int j = 0; j < KwLen[k]; j++) add_byte(KwWord[k][127-8*j -: 8]);
        add_byte(ChSpace);
      end
      2: begin
        n = $urandom_range(1, 10);
        for (int j = 0; j < n; j++)
          add_byte((j > 0 && $urandom_range(0, 3) == 0) ? 8'h30 + 8'($urandom_range(0, 9))
                   : 8'h61 + 8'($urandom_range(0, 25)));
        add_byte(8'h28);
      end
      3: begin
        // Cyrillic and three-byte groups, sometimes past the keyword length
        n = $urandom_range(1, 11);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 4) == 0) begin
            add_byte(8'($urandom_range(8'hE0, 8'hFF)));
            add_byte(8'($urandom_range(0, 255)));
            add_byte(8'($urandom_range(0, 255)));
          end else begin
            add_byte(8'hD0 + 8'($urandom_range(0, 1)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
          end
        end
        add_byte(ChLf);
      end
      4, 5: begin
        add_digits($urandom_range(1, 12));
        if ($urandom_range(0, 1)) begin
          add_byte(8'h2E);
          add_digits($urandom_range(0, 12));
        end
        add_byte($urandom_range(0, 3) == 0 ? 8'h2E : ChSpace);
      end
      6: begin
        add_byte(ChQuote);
        n = $urandom_range(0, 6);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte(ChBslash);
            case ($urandom_range(0, 5))
              0: add_byte(8'h6E);
              1: add_byte(8'h74);
              2: add_byte(8'h72);
              3: add_byte(ChQuote);
              4: add_byte(ChBslash);
              default: add_byte(8'($urandom_range(1, 255)));
            endcase
          end else add_byte(8'($urandom_range(8'h20, 8'hFF)));
        end
        add_byte($urandom_range(0, 4) == 0 ? ChLf : ChQuote);
      end
      7: begin
        add_byte(8'h2F);
        if ($urandom_range(0, 1)) begin
          add_byte(8'h2F);
          add_byte(8'h61);
          add_byte(ChLf);
        end else begin
          add_byte(8'h2A);
          n = $urandom_range(0, 4);
          for (int j = 0; j < n; j++) add_byte(8'($urandom_range(1, 255)));
          add_byte(8'h2A);
          add_byte(8'h2F);
        end
      end
      8, 9: begin
        case ($urandom_range(0, 3))
          0: add_byte(8'h3D);
          1: add_byte(8'h3C);
          2: add_byte(8'h3E);
          default: add_byte(8'h21);
        endcase
        if ($urandom_range(0, 1)) add_byte(8'h3D);
      end
      10: begin
        src_bytes.push_back(8'($urandom_range(0, 255)));
        src_eos.push_back(1'b1);
      end
      11: add_byte(ChLf);
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // Drive one request and wait for it to be taken
  task automatic send_byte(logic [7:0] b, logic eos);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    lex_byte(b, eos);
    bytes_taken++;
    @(negedge clk_i);
  endtask

  typedef struct {
    logic [7:0] b;
    logic       eos;
    logic [5:0] kind;  // kind of the step's last token, where typed in
  } row_t;

  row_t rows [$];
  int   burst_left;
  int   gap;

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    clear_token();
    lx_line = 16'd1;
    lx_col  = '0;
    lx_prev = '0;
    foreach (lx_name[i]) lx_name[i] = '0;

    rows = '{
      '{8'h41, 1'b1, TkEnd},      '{8'h28, 1'b0, TkLparen},  '{8'h3D, 1'b0, NoKind},
      '{8'h3D, 1'b0, TkEqEq},     '{8'h3C, 1'b0, NoKind},    '{8'h78, 1'b0, TkText},
      '{8'h21, 1'b0, NoKind},     '{8'h21, 1'b0, TkError},   '{8'h2F, 1'b0, TkError},
      '{8'h2A, 1'b0, NoKind},     '{8'h2A, 1'b0, NoKind},    '{8'h2F, 1'b0, NoKind},
      '{8'h39, 1'b0, NoKind},     '{8'h2E, 1'b0, NoKind},    '{8'h35, 1'b0, NoKind},
      '{8'h2E, 1'b0, TkDot},      '{8'h22, 1'b0, NoKind},    '{8'h5C, 1'b0, NoKind},
      '{8'h6E, 1'b0, TkText},     '{8'hFF, 1'b0, TkText},    '{8'h0A, 1'b0, TkNewline},
      '{8'hD0, 1'b0, TkText},     '{8'h00, 1'b0, TkEnd},     '{8'h3E, 1'b0, NoKind},
      '{8'h3D, 1'b0, TkGeq}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: typed kinds cross-check the predictor, which feeds the checker
    foreach (rows[i]) begin
      send_byte(rows[i].b, rows[i].eos);
      if (rows[i].kind != NoKind &&
          (step_tokens.size() == 0 || step_tokens[$].kind != rows[i].kind))
        report($sformatf("table row %0d kind", i),
               step_tokens.size() ? step_tokens[$].kind : NoKind, rows[i].kind);
    end

    // Random fragments in bursts with gaps
    while (src_bytes.size() < RandomItems) add_fragment();
    burst_left = 0;
    for (int i = 0; src_bytes.size() > 0; i++) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 5);
        burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      // Hold off once until the output has drained
      if (i == RandomItems / 2) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        while (tokens_due.size() != 0) @(negedge clk_i);
      end
      send_byte(src_bytes.pop_front(), src_eos.pop_front());
      burst_left--;
    end
    s_axis_tvalid <= 1'b0;

    while (tokens_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d source bytes (table and random fragments: keywords, names, numbers,",
             bytes_taken);
    $display("strings, comments, operators, noise); %0d tokens checked.", tokens_seen);
    if (errors == 0) begin
      $display("** source_tokenizer_core: PASSED **");
    end else begin
      $display("** source_tokenizer_core: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("Timeout with %0d tokens still due", tokens_due.size());
    $display("** source_tokenizer_core: FAILED **");
    $finish;
  end

endmodule
